FILE: rtl/core/mnfr_pkg.sv
`default_nettype none

package mnfr_pkg;

  localparam int unsigned FRAME_CAPACITY = 256;
  localparam int unsigned COUNT_W = $clog2(FRAME_CAPACITY + 1);

  localparam logic [7:0] START_CODE_RESET  = 8'hAA;
  localparam logic [7:0] STOP_CODE_RESET   = 8'h99;
  localparam logic [7:0] ESCAPE_CODE_RESET = 8'h66;

  // configuration register indexes
  localparam logic [1:0] REG_START_CODE  = 2'd0;
  localparam logic [1:0] REG_STOP_CODE   = 2'd1;
  localparam logic [1:0] REG_ESCAPE_CODE = 2'd2;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] stop_code;
    logic [7:0] escape_code;
  } codes_t;

  typedef struct packed {
    logic               expect_low_half;
    logic               escape_pending;
    logic               complete_flag;
    logic [COUNT_W-1:0] byte_count;
    logic [3:0]         low_nibble_hold;
  } frame_state_t;

  typedef struct packed {
    logic               byte_valid;
    logic [7:0]         decoded_byte;
    logic [7:0]         byte_index;
    logic               frame_complete;
    logic [COUNT_W-1:0] frame_length;
  } result_t;

  // the nibble rides in the odd bits of the line byte
  function automatic logic [3:0] odd_bits_nibble(input logic [7:0] b);
    return {b[7], b[5], b[3], b[1]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mnfr_step.sv
`default_nettype none

module mnfr_step (
  input  mnfr_pkg::codes_t       codes,
  input  mnfr_pkg::frame_state_t state_cur,
  input  logic [7:0]             line_byte,
  output mnfr_pkg::frame_state_t state_next,
  output mnfr_pkg::result_t      result
);
  import mnfr_pkg::*;

  localparam logic [COUNT_W-1:0] CAPACITY = COUNT_W'(FRAME_CAPACITY);

  logic               is_data;
  frame_state_t       st;
  logic [3:0]         nib;
  logic               take;

  always_comb begin
    st      = state_cur;
    is_data = 1'b0;
    // a pending escape makes any byte data; otherwise start wins over stop, stop over escape
    if (state_cur.escape_pending) begin
      st.escape_pending = 1'b0;
      is_data           = 1'b1;
    end else if (line_byte == codes.start_code) begin
      st.expect_low_half = 1'b1;
      st.escape_pending  = 1'b0;
      st.complete_flag   = 1'b0;
      st.byte_count      = '0;
    end else if (line_byte == codes.stop_code) begin
      st.complete_flag = 1'b1;
    end else if (line_byte == codes.escape_code) begin
      st.escape_pending = 1'b1;
    end else begin
      is_data = 1'b1;
    end

    nib  = odd_bits_nibble(line_byte);
    take = is_data && (st.byte_count < CAPACITY) && !st.complete_flag;

    result              = '0;
    state_next          = st;
    if (take) begin
      if (st.expect_low_half) begin
        state_next.low_nibble_hold = nib;
        state_next.expect_low_half = 1'b0;
      end else begin
        result.byte_valid          = 1'b1;
        result.decoded_byte        = {nib, st.low_nibble_hold};
        result.byte_index          = st.byte_count[7:0];
        state_next.byte_count      = st.byte_count + COUNT_W'(1);
        state_next.expect_low_half = 1'b1;
      end
    end
    result.frame_complete = state_next.complete_flag;
    result.frame_length   = state_next.byte_count;
  end

endmodule

`default_nettype wire

FILE: rtl/core/manchester_nibble_frame_receiver_core.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  line_byte
// out       source     out_valid/ out_stall byte_valid, decoded_byte, byte_index,
//                                           frame_complete, frame_length
// cfg       sink       cfg_write            cfg_index, cfg_data
//
// One line byte per cycle while in_stall is low; an input transfer loads the input
// register, and an advance then moves it through the decode step into the result register.
// The frame state updates in the single decode step between the input
// register and the result register.
// Reset is synchronous and restores the code registers to their defaults.
// A stall on the output holds the result register and, while the input register
// holds a byte, holds it as well and raises in_stall.

module manchester_nibble_frame_receiver_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               line_byte,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          byte_valid,
  output logic [7:0]                    decoded_byte,
  output logic [7:0]                    byte_index,
  output logic                          frame_complete,
  output logic [mnfr_pkg::COUNT_W-1:0]  frame_length,
  input  wire logic                     cfg_write,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [7:0]               cfg_data
);
  import mnfr_pkg::*;

  codes_t       codes;
  frame_state_t state_cur;
  frame_state_t state_next;
  result_t      step_result;
  result_t      result;

  logic         hold_valid;
  logic [7:0]   hold_byte;
  logic         out_free;
  logic         advance;

  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;

  mnfr_step u_step (
    .codes      (codes),
    .state_cur  (state_cur),
    .line_byte  (hold_byte),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.start_code          <= START_CODE_RESET;
      codes.stop_code           <= STOP_CODE_RESET;
      codes.escape_code         <= ESCAPE_CODE_RESET;
      state_cur.expect_low_half <= 1'b1;
      state_cur.escape_pending  <= 1'b0;
      state_cur.complete_flag   <= 1'b0;
      state_cur.byte_count      <= '0;
      state_cur.low_nibble_hold <= '0;
      hold_valid                <= 1'b0;
      out_valid                 <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_START_CODE:  codes.start_code  <= cfg_data;
          REG_STOP_CODE:   codes.stop_code   <= cfg_data;
          REG_ESCAPE_CODE: codes.escape_code <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        state_cur <= state_next;
      end
      if (!in_stall) begin
        hold_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= hold_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= line_byte;
    end
    if (advance) begin
      result <= step_result;
    end
  end

  assign byte_valid     = result.byte_valid;
  assign decoded_byte   = result.decoded_byte;
  assign byte_index     = result.byte_index;
  assign frame_complete = result.frame_complete;
  assign frame_length   = result.frame_length;

endmodule

`default_nettype wire
